// ===== hdl/event_flag_group_unit_defines.svh =====
// Assertion macros shared by the event flag group RTL.
// Depends on clk and rst_n being visible where a macro is used.
`ifndef EVENT_FLAG_GROUP_UNIT_DEFINES_SVH
`define EVENT_FLAG_GROUP_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define EFG_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define EFG_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/efg_pkg.sv =====
// Shared types, codes and constants of the event flag group.
// No dependencies.
package efg_pkg;

    localparam int WAITER_SLOTS_DEF = 8;
    localparam int DATA_W           = 32;
    localparam int SLOT_BITS        = 3;
    localparam int CMD_DEPTH        = 2;
    localparam int RES_DEPTH        = 4;
    localparam int CFG_IDX_W        = 1;

    // Operation codes on the input side
    localparam logic [1:0] OP_SET     = 2'd0;
    localparam logic [1:0] OP_WAIT    = 2'd1;
    localparam logic [1:0] OP_TIMEOUT = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_MASK     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_DISABLE = 1'b1;

    typedef enum logic [1:0] {
        K_SET,
        K_WAIT,
        K_TIMEOUT,
        K_NONE
    } kind_t;

    typedef enum logic [2:0] {
        STAT_WOKEN,
        STAT_BLOCKED,
        STAT_TIMEOUT,
        STAT_NOBODY,
        STAT_SLOTERR
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    // Classified command: word_a/b/c are set/clear/toggle for a set,
    // desired/listen/group for a wait.
    typedef struct packed {
        kind_t               kind;
        logic [SLOT_BITS-1:0] slot;
        logic                slot_ok;
        logic [DATA_W-1:0]   word_a;
        logic [DATA_W-1:0]   word_b;
        logic [DATA_W-1:0]   word_c;
    } cmd_t;

    typedef struct packed {
        logic [SLOT_BITS-1:0] slot;
        status_t              status;
        logic [DATA_W-1:0]    bits;
        logic                 last;
    } res_t;

    // Only slots 0..7 are addressable, so at most eight are ever scanned
    function automatic int active_slots(input int n);
        return (n < 8) ? n : 8;
    endfunction

endpackage

// ===== hdl/efg_fifo.sv =====
// Small register queue with push/full and pop/empty sides.
// No dependencies.
module efg_fifo #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_push = push & ~full;
    assign do_pop  = pop & ~empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== hdl/efg_front.sv =====
// Front end: accept input words, decode the operation, queue commands.
// Depends on efg_pkg and efg_fifo.
module efg_front #(
    parameter int WAITER_SLOTS = efg_pkg::WAITER_SLOTS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [1:0]                     operation,
    input  logic [efg_pkg::DATA_W-1:0]     set_bits,
    input  logic [efg_pkg::DATA_W-1:0]     clear_bits,
    input  logic [efg_pkg::DATA_W-1:0]     toggle_bits,
    input  logic [efg_pkg::SLOT_BITS-1:0]  slot_index,
    input  logic [efg_pkg::DATA_W-1:0]     desired_bits,
    input  logic [efg_pkg::DATA_W-1:0]     listen_bits,
    input  logic [efg_pkg::DATA_W-1:0]     group_bits,
    output efg_pkg::cmd_t                  cmd,
    output logic                           cmd_empty,
    input  logic                           cmd_pop
);
    import efg_pkg::*;

    localparam logic [6:0] SLOT_LIMIT = 7'(WAITER_SLOTS);

    cmd_t                 cmd_in;
    logic [$bits(cmd_t)-1:0] cmd_raw;

    // Fold the two operand groups onto shared words
    always_comb
    begin
        cmd_in.slot    = slot_index;
        cmd_in.slot_ok = ({4'b0, slot_index} < SLOT_LIMIT);
        cmd_in.kind    = K_NONE;
        cmd_in.word_a  = '0;
        cmd_in.word_b  = '0;
        cmd_in.word_c  = '0;
        case (operation)
            OP_SET:
            begin
                cmd_in.kind   = K_SET;
                cmd_in.word_a = set_bits;
                cmd_in.word_b = clear_bits;
                cmd_in.word_c = toggle_bits;
            end
            OP_WAIT:
            begin
                cmd_in.kind   = K_WAIT;
                cmd_in.word_a = desired_bits;
                cmd_in.word_b = listen_bits;
                cmd_in.word_c = group_bits;
            end
            OP_TIMEOUT:
            begin
                cmd_in.kind = K_TIMEOUT;
            end
            default:
            begin
                cmd_in.kind = K_NONE;
            end
        endcase
    end

    efg_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (cmd_in),
        .full  (full),
        .pop   (cmd_pop),
        .rdata (cmd_raw),
        .empty (cmd_empty)
    );

    assign cmd = cmd_t'(cmd_raw);

endmodule

// ===== hdl/efg_back.sv =====
// Back end: flag state, waiter slot table and the wake-up scan sequencer.
// Depends on efg_pkg and event_flag_group_unit_defines.svh.
`include "event_flag_group_unit_defines.svh"

module efg_back #(
    parameter int WAITER_SLOTS = efg_pkg::WAITER_SLOTS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [efg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [efg_pkg::DATA_W-1:0]     cfg_data,
    input  efg_pkg::cmd_t                  cmd,
    input  logic                           cmd_empty,
    output logic                           cmd_pop,
    output logic                           res_push,
    output efg_pkg::res_t                  res_word,
    input  logic                           res_full
);
    import efg_pkg::*;

    localparam int NSLOT  = active_slots(WAITER_SLOTS);
    localparam int SLOT_W = (NSLOT > 1) ? $clog2(NSLOT) : 1;
    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(NSLOT - 1);

    state_t                state_reg, state_next;
    logic [DATA_W-1:0]     edge_mask_reg, edge_mask_next;
    logic [DATA_W-1:0]     keep_mask_reg, keep_mask_next;
    logic [DATA_W-1:0]     flag_reg, flag_next;
    logic [DATA_W-1:0]     pend_reg, pend_next;
    logic [DATA_W-1:0]     report_reg, report_next;
    logic [DATA_W-1:0]     reported_reg, reported_next;
    logic [SLOT_W-1:0]     scan_idx_reg, scan_idx_next;
    logic                  hold_valid_reg, hold_valid_next;
    logic [SLOT_BITS-1:0]  hold_slot_reg, hold_slot_next;
    logic [DATA_W-1:0]     hold_bits_reg, hold_bits_next;
    logic [NSLOT-1:0]      waiting_reg, waiting_next;

    logic [DATA_W-1:0]     desired_reg   [NSLOT];
    logic [DATA_W-1:0]     listen_reg    [NSLOT];
    logic [DATA_W-1:0]     group_reg     [NSLOT];
    logic [DATA_W-1:0]     collected_reg [NSLOT];

    logic [SLOT_W-1:0]     slot_idx;
    logic                  slot_busy;
    logic [DATA_W-1:0]     level_word;
    logic [DATA_W-1:0]     wait_got;
    logic                  wait_wake;
    logic [DATA_W-1:0]     set_value;
    logic [DATA_W-1:0]     set_defer;
    logic [DATA_W-1:0]     scan_got;
    logic [DATA_W-1:0]     scan_coll;
    logic                  scan_wake;
    logic                  slot_wr;
    logic                  coll_wr;
    logic [DATA_W-1:0]     coll_wdata;

    // One table port: scan position while scanning, else the command's slot
    assign slot_idx   = (state_reg == S_SCAN) ? scan_idx_reg : cmd.slot[SLOT_W-1:0];
    assign slot_busy  = waiting_reg[slot_idx];
    assign level_word = (pend_reg & edge_mask_reg) | (flag_reg & ~edge_mask_reg);
    assign wait_got   = ~(level_word ^ cmd.word_a) & cmd.word_b;
    assign wait_wake  = (wait_got != '0) &&
                        ((cmd.word_c == '0) || ((wait_got & cmd.word_c) == cmd.word_c));
    assign set_value  = ((flag_reg & ~cmd.word_b) | cmd.word_a) ^ cmd.word_c;
    assign set_defer  = pend_reg | (set_value ^ flag_reg);
    assign scan_got   = ~(report_reg ^ desired_reg[slot_idx]) & listen_reg[slot_idx]
                        & {DATA_W{slot_busy}};
    assign scan_coll  = collected_reg[slot_idx] | scan_got;
    assign scan_wake  = (scan_got != '0) &&
                        ((group_reg[slot_idx] == '0) ||
                         ((scan_coll & group_reg[slot_idx]) == group_reg[slot_idx]));

    always_comb
    begin
        edge_mask_next = edge_mask_reg;
        keep_mask_next = keep_mask_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_EDGE_MASK:     edge_mask_next = cfg_data;
                CFG_CLEAR_DISABLE: keep_mask_next = cfg_data;
                default:           edge_mask_next = edge_mask_reg;
            endcase
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        flag_next       = flag_reg;
        pend_next       = pend_reg;
        report_next     = report_reg;
        reported_next   = reported_reg;
        scan_idx_next   = scan_idx_reg;
        hold_valid_next = hold_valid_reg;
        hold_slot_next  = hold_slot_reg;
        hold_bits_next  = hold_bits_reg;
        waiting_next    = waiting_reg;
        cmd_pop         = 1'b0;
        res_push        = 1'b0;
        res_word        = '{slot: '0, status: STAT_NOBODY, bits: '0, last: 1'b1};
        slot_wr         = 1'b0;
        coll_wr         = 1'b0;
        coll_wdata      = wait_got;

        case (state_reg)
            S_IDLE:
            begin
                if (!cmd_empty && !res_full)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.kind)
                        K_SET:
                        begin
                            // Apply the update now; consume after the scan
                            flag_next       = set_value;
                            pend_next       = set_defer;
                            report_next     = (set_defer & edge_mask_reg)
                                              | (set_value & ~edge_mask_reg);
                            reported_next   = '0;
                            hold_valid_next = 1'b0;
                            scan_idx_next   = '0;
                            state_next      = S_SCAN;
                        end
                        K_WAIT:
                        begin
                            res_push = 1'b1;
                            if (!cmd.slot_ok || slot_busy)
                            begin
                                res_word = '{slot: cmd.slot, status: STAT_SLOTERR,
                                             bits: '0, last: 1'b1};
                            end
                            else
                            begin
                                slot_wr   = 1'b1;
                                pend_next = pend_reg & ~wait_got;
                                flag_next = flag_reg & ~(wait_got & ~keep_mask_reg);
                                if (wait_wake)
                                begin
                                    res_word = '{slot: cmd.slot, status: STAT_WOKEN,
                                                 bits: wait_got, last: 1'b1};
                                end
                                else
                                begin
                                    waiting_next[slot_idx] = 1'b1;
                                    res_word = '{slot: cmd.slot, status: STAT_BLOCKED,
                                                 bits: wait_got, last: 1'b1};
                                end
                            end
                        end
                        K_TIMEOUT:
                        begin
                            res_push = 1'b1;
                            if (!cmd.slot_ok || !slot_busy)
                            begin
                                res_word = '{slot: cmd.slot, status: STAT_SLOTERR,
                                             bits: '0, last: 1'b1};
                            end
                            else
                            begin
                                waiting_next[slot_idx] = 1'b0;
                                res_word = '{slot: cmd.slot, status: STAT_TIMEOUT,
                                             bits: collected_reg[slot_idx], last: 1'b1};
                            end
                        end
                        default:
                        begin
                            res_push = 1'b1;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                if (!res_full)
                begin
                    if (scan_got != '0)
                    begin
                        coll_wr       = 1'b1;
                        coll_wdata    = scan_coll;
                        reported_next = reported_reg | scan_got;
                        if (scan_wake)
                        begin
                            waiting_next[slot_idx] = 1'b0;
                            // Release the previous wake; this one may be the final word
                            if (hold_valid_reg)
                            begin
                                res_push = 1'b1;
                                res_word = '{slot: hold_slot_reg, status: STAT_WOKEN,
                                             bits: hold_bits_reg, last: 1'b0};
                            end
                            hold_valid_next = 1'b1;
                            hold_slot_next  = SLOT_BITS'(scan_idx_reg);
                            hold_bits_next  = scan_coll;
                        end
                    end
                    if (scan_idx_reg == LAST_IDX)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        scan_idx_next = scan_idx_reg + 1'b1;
                    end
                end
            end

            S_FINISH:
            begin
                if (!res_full)
                begin
                    res_push = 1'b1;
                    if (hold_valid_reg)
                    begin
                        res_word = '{slot: hold_slot_reg, status: STAT_WOKEN,
                                     bits: hold_bits_reg, last: 1'b1};
                    end
                    pend_next       = pend_reg & ~reported_reg;
                    flag_next       = flag_reg & ~(reported_reg & ~keep_mask_reg);
                    hold_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            edge_mask_reg  <= '0;
            keep_mask_reg  <= '0;
            flag_reg       <= '0;
            pend_reg       <= '0;
            waiting_reg    <= '0;
            hold_valid_reg <= 1'b0;
            scan_idx_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            edge_mask_reg  <= edge_mask_next;
            keep_mask_reg  <= keep_mask_next;
            flag_reg       <= flag_next;
            pend_reg       <= pend_next;
            waiting_reg    <= waiting_next;
            hold_valid_reg <= hold_valid_next;
            scan_idx_reg   <= scan_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        report_reg    <= report_next;
        reported_reg  <= reported_next;
        hold_slot_reg <= hold_slot_next;
        hold_bits_reg <= hold_bits_next;
    end

    // Slot table: written by a wait, collected bits also by the scan
    always_ff @(posedge clk)
    begin
        if (slot_wr)
        begin
            desired_reg[slot_idx] <= cmd.word_a;
            listen_reg[slot_idx]  <= cmd.word_b;
            group_reg[slot_idx]   <= cmd.word_c;
        end
        if (slot_wr || coll_wr)
        begin
            collected_reg[slot_idx] <= coll_wdata;
        end
    end

    `EFG_ASSERT_NOW(a_push_has_room, res_push, !res_full, "result pushed into a full queue")
    `EFG_ASSERT_NOW(a_pop_in_idle, cmd_pop, state_reg == S_IDLE, "command taken outside idle")
    `EFG_ASSERT_NOW(a_scan_in_range, state_reg == S_SCAN, 32'(scan_idx_reg) < NSLOT, "scan past table")
    `EFG_ASSERT_NOW(a_idle_no_hold, state_reg == S_IDLE, !hold_valid_reg, "held wake left in idle")
    `EFG_ASSERT_NEXT(a_finish_closes, state_reg == S_FINISH && !res_full, state_reg == S_IDLE, "finish stuck")

endmodule

// ===== hdl/event_flag_group_unit.sv =====
// Top level of the event flag group with waiter slots.
// Depends on efg_pkg, efg_front, efg_back and efg_fifo.
//
// Usage:
//   Input channel: drive the operation word and push it while full is low.
//   Operations are set/clear/toggle, wait by a slot and timeout of a slot.
//   Result channel: a word is on woken_slot/status/delivered_bits/last while
//   empty is low; pop takes it. Every input yields one or more result words,
//   the final one marked by last.
//   Configuration: cfg_write with cfg_index 0 (edge mask) or 1 (clear-disable
//   mask) writes cfg_data at once; write only while the block is idle.
//   Flow: a word enters a two-entry command queue, then the executor takes
//   it. Wait, timeout and unknown codes are executed from idle and push
//   their result word when taken. A set updates the flags in idle, scans the
//   waiter slots in ascending order (at most eight), then consumes the
//   reported bits and closes in the finish state.
//   Stall: when the four-entry result queue fills, the executor holds its
//   place; the command queue still takes words until it fills too.
//   Reset: flags, pending edges, both masks and all waiting marks clear;
//   both queues empty. No clearing pass.
module event_flag_group_unit #(
    parameter int WAITER_SLOTS = efg_pkg::WAITER_SLOTS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [efg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [efg_pkg::DATA_W-1:0]     cfg_data,
    input  logic                           push,
    output logic                           full,
    input  logic [1:0]                     operation,
    input  logic [efg_pkg::DATA_W-1:0]     set_bits,
    input  logic [efg_pkg::DATA_W-1:0]     clear_bits,
    input  logic [efg_pkg::DATA_W-1:0]     toggle_bits,
    input  logic [efg_pkg::SLOT_BITS-1:0]  slot_index,
    input  logic [efg_pkg::DATA_W-1:0]     desired_bits,
    input  logic [efg_pkg::DATA_W-1:0]     listen_bits,
    input  logic [efg_pkg::DATA_W-1:0]     group_bits,
    output logic                           empty,
    input  logic                           pop,
    output logic [efg_pkg::SLOT_BITS-1:0]  woken_slot,
    output logic [2:0]                     status,
    output logic [efg_pkg::DATA_W-1:0]     delivered_bits,
    output logic                           last
);
    import efg_pkg::*;

    cmd_t                    cmd;
    logic                    cmd_empty;
    logic                    cmd_pop;
    logic                    res_push;
    res_t                    res_word;
    logic                    res_full;
    logic [$bits(res_t)-1:0] res_raw;
    res_t                    res_head;

    // Decode and queue incoming words
    efg_front #(
        .WAITER_SLOTS (WAITER_SLOTS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .operation    (operation),
        .set_bits     (set_bits),
        .clear_bits   (clear_bits),
        .toggle_bits  (toggle_bits),
        .slot_index   (slot_index),
        .desired_bits (desired_bits),
        .listen_bits  (listen_bits),
        .group_bits   (group_bits),
        .cmd          (cmd),
        .cmd_empty    (cmd_empty),
        .cmd_pop      (cmd_pop)
    );

    // Execute commands against the flag state and slot table
    efg_back #(
        .WAITER_SLOTS (WAITER_SLOTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .res_push  (res_push),
        .res_word  (res_word),
        .res_full  (res_full)
    );

    // Hold results until the receiver pops them
    efg_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_word),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_raw),
        .empty (empty)
    );

    assign res_head       = res_t'(res_raw);
    assign woken_slot     = res_head.slot;
    assign status         = res_head.status;
    assign delivered_bits = res_head.bits;
    assign last           = res_head.last;

endmodule

// ===== bench/event_flag_group_unit_tb.sv =====
// Self-checking bench for event_flag_group_unit: flag updates, waits and timeouts on
// the waiter slots, predicted word by word against a behavioral copy of the block.
// Depends on efg_pkg and the event_flag_group_unit RTL.
`timescale 1ns / 100ps

module event_flag_group_unit_tb;
    import efg_pkg::*;

    localparam int SLOTS       = 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_GAP  = 16;
    // The block has no name for the spare operation code
    localparam logic [1:0] OP_NONE = 2'd3;

    // One command word as offered on the input side
    typedef struct {
        logic [1:0]  op;
        logic [31:0] set_w;
        logic [31:0] clr_w;
        logic [31:0] tog_w;
        logic [2:0]  slot;
        logic [31:0] desired;
        logic [31:0] listen;
        logic [31:0] group_w;
    } flag_cmd_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic [0:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        push = 1'b0;
    logic        full;
    logic [1:0]  operation = '0;
    logic [31:0] set_bits = '0;
    logic [31:0] clear_bits = '0;
    logic [31:0] toggle_bits = '0;
    logic [2:0]  slot_index = '0;
    logic [31:0] desired_bits = '0;
    logic [31:0] listen_bits = '0;
    logic [31:0] group_bits = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [2:0]  woken_slot;
    logic [2:0]  status;
    logic [31:0] delivered_bits;
    logic        last;

    event_flag_group_unit u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .push           (push),
        .full           (full),
        .operation      (operation),
        .set_bits       (set_bits),
        .clear_bits     (clear_bits),
        .toggle_bits    (toggle_bits),
        .slot_index     (slot_index),
        .desired_bits   (desired_bits),
        .listen_bits    (listen_bits),
        .group_bits     (group_bits),
        .empty          (empty),
        .pop            (pop),
        .woken_slot     (woken_slot),
        .status         (status),
        .delivered_bits (delivered_bits),
        .last           (last)
    );

    // 2 ns clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the flag group: registers, flags and waiter table
    // ------------------------------------------------------------------
    logic [31:0] edge_sel;      // edge_mask register
    logic [31:0] keep_sel;      // clear_disable_mask register
    logic [31:0] flag_word;
    logic [31:0] edge_word;     // pending edges
    bit          parked   [SLOTS];
    logic [31:0] listen_m [SLOTS];
    logic [31:0] desired_m[SLOTS];
    logic [31:0] group_m  [SLOTS];
    logic [31:0] gathered [SLOTS];

    // Result words owed by the block, oldest first
    res_t due_results[$];

    int send_gap_pct  = 0;   // chance per cycle that the sender stays idle
    int pop_stall_pct = 0;   // chance per cycle that the receiver stalls
    int pop_hold      = 0;   // forced receiver hold-off, in cycles
    int cycles        = 0;
    int failures      = 0;
    int words_sent    = 0;
    int words_checked = 0;
    int wakes_seen    = 0;

    function automatic void owe_result(input logic [2:0] slot, input status_t st,
                                       input logic [31:0] bits, input logic fin);
        res_t r;
        r.slot   = slot;
        r.status = st;
        r.bits   = bits;
        r.last   = fin;
        due_results.push_back(r);
    endfunction

    // Drop reported bits from the pending edges, and from the flags unless kept
    function automatic void retire_bits(input logic [31:0] taken);
        edge_word = edge_word & ~taken;
        flag_word = flag_word & ~(taken & ~keep_sel);
    endfunction

    // Flag update followed by the wake scan in ascending slot order
    function automatic void predict_set(input flag_cmd_t c);
        logic [31:0] nv;
        logic [31:0] moved;
        logic [31:0] rep;
        logic [31:0] taken;
        logic [31:0] got;
        bit          wake;
        bit          have_held;
        logic [2:0]  held_slot;
        logic [31:0] held_bits;
        nv = ((flag_word & ~c.clr_w) | c.set_w) ^ c.tog_w;
        moved = edge_word | (nv ^ flag_word);
        rep = (moved & edge_sel) | (nv & ~edge_sel);
        taken = '0;
        have_held = 1'b0;
        held_slot = '0;
        held_bits = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (parked[i])
            begin
                got = ~(rep ^ desired_m[i]) & listen_m[i];
                if (got != '0)
                begin
                    gathered[i] = gathered[i] | got;
                    taken = taken | got;
                    if (group_m[i] != '0)
                        wake = (gathered[i] & group_m[i]) == group_m[i];
                    else
                        wake = 1'b1;
                    if (wake)
                    begin
                        parked[i] = 1'b0;
                        // hold each wake back one step so the final one gets last
                        if (have_held)
                            owe_result(held_slot, STAT_WOKEN, held_bits, 1'b0);
                        have_held = 1'b1;
                        held_slot = 3'(i);
                        held_bits = gathered[i];
                    end
                end
            end
        end
        flag_word = nv;
        edge_word = moved;
        retire_bits(taken);
        if (have_held)
            owe_result(held_slot, STAT_WOKEN, held_bits, 1'b1);
        else
            owe_result(3'd0, STAT_NOBODY, '0, 1'b1);
    endfunction

    // Wait: reject a parked slot, else check the report word at once, wake or park the slot
    function automatic void predict_wait(input flag_cmd_t c);
        logic [31:0] rep;
        logic [31:0] got;
        if (parked[c.slot])
        begin
            owe_result(c.slot, STAT_SLOTERR, '0, 1'b1);
            return;
        end
        listen_m[c.slot] = c.listen;
        desired_m[c.slot] = c.desired;
        group_m[c.slot] = c.group_w;
        gathered[c.slot] = '0;
        rep = (edge_word & edge_sel) | (flag_word & ~edge_sel);
        got = ~(rep ^ c.desired) & c.listen;
        if (got != '0)
        begin
            gathered[c.slot] = got;
            retire_bits(got);
            if (c.group_w == '0 || (got & c.group_w) == c.group_w)
            begin
                owe_result(c.slot, STAT_WOKEN, got, 1'b1);
                return;
            end
        end
        parked[c.slot] = 1'b1;
        owe_result(c.slot, STAT_BLOCKED, gathered[c.slot], 1'b1);
    endfunction

    function automatic void predict_timeout(input flag_cmd_t c);
        if (!parked[c.slot])
            owe_result(c.slot, STAT_SLOTERR, '0, 1'b1);
        else
        begin
            parked[c.slot] = 1'b0;
            owe_result(c.slot, STAT_TIMEOUT, gathered[c.slot], 1'b1);
        end
    endfunction

    function automatic void forecast_results(input flag_cmd_t c);
        case (c.op)
            OP_SET:     predict_set(c);
            OP_WAIT:    predict_wait(c);
            OP_TIMEOUT: predict_timeout(c);
            default:    owe_result(3'd0, STAT_NOBODY, '0, 1'b1);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Words of uneven density: empty, full, one bit, sparse or dense
    function automatic logic [31:0] mixed_word();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return 32'h1 << $urandom_range(31);
            3, 4:    return $urandom & $urandom & $urandom;
            default: return $urandom;
        endcase
    endfunction

    // Slot that is (or is not) parked, starting from a random point; any slot if none
    function automatic logic [2:0] pick_slot(input bit want_parked);
        int base;
        base = $urandom_range(SLOTS - 1);
        for (int k = 0; k < SLOTS; k++)
            if (parked[(base + k) % SLOTS] == want_parked)
                return 3'((base + k) % SLOTS);
        return 3'(base);
    endfunction

    function automatic flag_cmd_t make_cmd(input logic [1:0] op, input logic [2:0] slot,
                                           input logic [31:0] a, input logic [31:0] b,
                                           input logic [31:0] c3);
        flag_cmd_t c;
        c.op = op;
        c.slot = slot;
        c.set_w = a;
        c.clr_w = b;
        c.tog_w = c3;
        c.desired = a;
        c.listen = b;
        c.group_w = c3;
        return c;
    endfunction

    // Mostly well-formed traffic: park waiters, then drive flags toward them
    function automatic flag_cmd_t build_random_cmd();
        flag_cmd_t c;
        int        roll;
        int        t;
        logic [31:0] m;
        c.op = OP_SET;
        c.set_w = $urandom;
        c.clr_w = $urandom;
        c.tog_w = $urandom;
        c.slot = 3'($urandom_range(7));
        c.desired = $urandom;
        c.listen = $urandom;
        c.group_w = $urandom;
        roll = $urandom_range(99);
        if (roll < 45)
        begin
            c.op = OP_SET;
            if ($urandom_range(99) < 60)
            begin
                // aim at one parked slot's listen bits, toward its desired levels
                t = int'(pick_slot(1'b1));
                m = $urandom_range(1) ? 32'hFFFF_FFFF : $urandom;
                c.set_w = (desired_m[t] & listen_m[t] & m) | ($urandom & $urandom & $urandom);
                c.clr_w = ~desired_m[t] & listen_m[t] & m;
                c.tog_w = ($urandom_range(3) == 0) ? mixed_word() : '0;
            end
            else
            begin
                c.set_w = mixed_word();
                c.clr_w = mixed_word();
                c.tog_w = ($urandom_range(2) == 0) ? mixed_word() : '0;
            end
        end
        else if (roll < 80)
        begin
            c.op = OP_WAIT;
            c.slot = ($urandom_range(99) < 85) ? pick_slot(1'b0) : 3'($urandom_range(7));
            c.desired = $urandom_range(1) ? mixed_word() : $urandom;
            c.listen = ($urandom_range(3) == 0) ? mixed_word() : ($urandom & $urandom & $urandom);
            case ($urandom_range(9))
                0, 1, 2, 3, 4: c.group_w = '0;
                5, 6:          c.group_w = c.listen;
                7, 8:          c.group_w = c.listen & $urandom;
                default:       c.group_w = mixed_word();
            endcase
        end
        else if (roll < 95)
        begin
            c.op = OP_TIMEOUT;
            c.slot = ($urandom_range(99) < 80) ? pick_slot(1'b1) : 3'($urandom_range(7));
        end
        else
            c.op = OP_NONE;
        return c;
    endfunction

    // Offer one word; on acceptance leave push high, the next call or settle decides
    task automatic send_cmd(input flag_cmd_t c);
        if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct)
        begin
            push <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_gap_pct);
        end
        push         <= 1'b1;
        operation    <= c.op;
        set_bits     <= c.set_w;
        clear_bits   <= c.clr_w;
        toggle_bits  <= c.tog_w;
        slot_index   <= c.slot;
        desired_bits <= c.desired;
        listen_bits  <= c.listen;
        group_bits   <= c.group_w;
        // full is sampled as it stood at the edge
        do
            @(posedge clk);
        while (full);
        forecast_results(c);
        words_sent++;
    endtask

    // Drop push, wait out every owed word, then let the executor finish
    task automatic settle();
        push <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_GAP) @(posedge clk);
    endtask

    // Write both registers back to back; only call while idle
    task automatic write_masks(input logic [31:0] edge_val, input logic [31:0] keep_val);
        cfg_write <= 1'b1;
        cfg_index <= CFG_EDGE_MASK;
        cfg_data  <= edge_val;
        @(posedge clk);
        edge_sel = edge_val;
        cfg_index <= CFG_CLEAR_DISABLE;
        cfg_data  <= keep_val;
        @(posedge clk);
        keep_sel = keep_val;
        cfg_write <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Receiver and checker: compare each popped word with the oldest owed one
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        res_t owed;
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                words_checked++;
                if (status == STAT_WOKEN)
                    wakes_seen++;
                if (due_results.size() == 0)
                begin
                    $display("%0t: unexpected word slot %0d status %0d bits %h last %0b",
                             $time, woken_slot, status, delivered_bits, last);
                    failures++;
                end
                else
                begin
                    owed = due_results.pop_front();
                    if (woken_slot !== owed.slot)
                    begin
                        $display("%0t: woken_slot expected %0d actual %0d",
                                 $time, owed.slot, woken_slot);
                        failures++;
                    end
                    if (status !== owed.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, owed.status, status);
                        failures++;
                    end
                    if (delivered_bits !== owed.bits)
                    begin
                        $display("%0t: delivered_bits expected %h actual %h",
                                 $time, owed.bits, delivered_bits);
                        failures++;
                    end
                    if (last !== owed.last)
                    begin
                        $display("%0t: last expected %0b actual %0b",
                                 $time, owed.last, last);
                        failures++;
                    end
                end
            end
            // forced hold-off first, then random stalls
            if (pop_hold > 0)
            begin
                pop_hold--;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(99) >= pop_stall_pct);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("%0t: no progress, %0d words still owed", $time, due_results.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hand-picked words at reset masks: every operation and the corner cases
    task automatic test_directed_ops();
        send_gap_pct = 0;
        pop_stall_pct = 0;
        // set everything with no waiter parked: nobody woken
        send_cmd(make_cmd(OP_SET, 3'd0, '1, '0, '0));
        // timeout of an idle slot
        send_cmd(make_cmd(OP_TIMEOUT, 3'd3, '0, '0, '0));
        // spare code with every field at its top value
        send_cmd(make_cmd(OP_NONE, 3'd7, '1, '1, '1));
        // wait that wakes at once
        send_cmd(make_cmd(OP_WAIT, 3'd0, '1, 32'h0000_000F, '0));
        // wait that blocks with nothing collected, then a second wait on it
        send_cmd(make_cmd(OP_WAIT, 3'd1, '1, 32'h0000_000F, '0));
        send_cmd(make_cmd(OP_WAIT, 3'd1, '1, 32'h0000_000F, '0));
        // part of a group collected: slot keeps it and blocks
        send_cmd(make_cmd(OP_WAIT, 3'd2, '1, 32'h0000_FF00, 32'h00FF_FF00));
        // clear all, raise the low nibble: wakes slot 1 only
        send_cmd(make_cmd(OP_SET, 3'd0, 32'h0000_000F, '1, '0));
        // release the partial group, then time out an idle slot
        send_cmd(make_cmd(OP_TIMEOUT, 3'd2, '0, '0, '0));
        send_cmd(make_cmd(OP_TIMEOUT, 3'd2, '0, '0, '0));
        // park every slot on its own bit, then wake all eight with one set
        for (int i = 0; i < SLOTS; i++)
            send_cmd(make_cmd(OP_WAIT, 3'(i), '1, 32'h1 << (4 * i), '0));
        send_cmd(make_cmd(OP_SET, 3'd0, '1, '0, '0));
        // toggle only
        send_cmd(make_cmd(OP_SET, 3'd0, '0, '0, 32'hFFFF_0000));
        // wait for zero levels across the whole word as one group
        send_cmd(make_cmd(OP_WAIT, 3'd5, '0, '1, '1));
        send_cmd(make_cmd(OP_TIMEOUT, 3'd5, '0, '0, '0));
        // set and clear of the same bits: set wins
        send_cmd(make_cmd(OP_SET, 3'd0, '1, '1, '0));
        // all-zero set
        send_cmd(make_cmd(OP_SET, 3'd0, '0, '0, '0));
        settle();
    endtask

    // Random traffic under one register setting and one idle pattern
    task automatic test_random_traffic(input int count, input logic [31:0] edge_val,
                                       input logic [31:0] keep_val, input int gap_pct,
                                       input int stall_pct);
        settle();
        write_masks(edge_val, keep_val);
        send_gap_pct = gap_pct;
        pop_stall_pct = stall_pct;
        repeat (count) send_cmd(build_random_cmd());
        settle();
    endtask

    // Hold the output off long enough that both queues fill and full rises
    task automatic test_backpressure();
        settle();
        write_masks($urandom, $urandom);
        send_gap_pct = 0;
        pop_stall_pct = 0;
        pop_hold = 150;
        repeat (16) send_cmd(build_random_cmd());
        settle();
    endtask

    initial
    begin
        edge_sel  = '0;
        keep_sel  = '0;
        flag_word = '0;
        edge_word = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            parked[i]    = 1'b0;
            listen_m[i]  = '0;
            desired_m[i] = '0;
            group_m[i]   = '0;
            gathered[i]  = '0;
        end
        // hold reset low, then release it once
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_ops();
        test_random_traffic(34, 32'h0000_0000, 32'h0000_0000, 0, 0);
        test_random_traffic(34, 32'hFFFF_FFFF, 32'h0000_0000, 53, 0);
        test_random_traffic(34, 32'h0000_0000, 32'hFFFF_FFFF, 0, 53);
        test_random_traffic(34, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 28, 28);
        test_random_traffic(34, $urandom, $urandom, 0, 0);
        test_backpressure();

        $display("Sent %0d command words and checked %0d result words (%0d wakes),",
                 words_sent, words_checked, wakes_seen);
        $display("over six register settings, four idle patterns and one output stall.");
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
